FILE: rtl/core/tahoe_congestion_window_control_assert.svh
// Assertion macros shared by the congestion window controller RTL.
// Each macro expands to one labeled concurrent assertion that reports by $error.
`ifndef TAHOE_CONGESTION_WINDOW_CONTROL_ASSERT_SVH
`define TAHOE_CONGESTION_WINDOW_CONTROL_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TCW_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define TCW_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/tcw_pkg.sv
// Types and constants of the congestion window controller.
// No dependencies; used by the channel interfaces and the top level.
`default_nettype none

package tcw_pkg;

  localparam int unsigned CfgAddrW = 4;
  localparam int unsigned WinCap   = 32;
  localparam int unsigned MaxWindow = 32;

  localparam logic [15:0] SeqOffsetRst = 16'd1000;
  localparam logic [11:0] DataLenRst   = 12'd2048;
  localparam logic [7:0]  InitThrRst   = 8'd16;

  localparam logic [15:0] CwndOne    = 16'd256;
  localparam logic [16:0] CwndCap    = 17'(MaxWindow) << 8;
  localparam logic [8:0]  CwndStep   = 9'd256;
  localparam logic [3:0]  DivLastStep = 4'd8;
  localparam logic [2:0]  CntMax     = 3'd7;
  localparam logic [2:0]  DupLimit   = 3'd3;

  typedef enum logic [1:0] {
    ACT_ROUND   = 2'd0,
    ACT_ACK     = 2'd1,
    ACT_TIMEOUT = 2'd2,
    ACT_RTX_ACK = 2'd3
  } tcw_action_e;

  typedef enum logic [2:0] {
    KIND_WINDOW     = 3'd0,
    KIND_SEND       = 3'd1,
    KIND_RETRANSMIT = 3'd2,
    KIND_DONE       = 3'd3,
    KIND_ACK        = 3'd4
  } tcw_kind_e;

  typedef enum logic [1:0] {
    REG_SEQ_OFFSET  = 2'd0,
    REG_DATA_LENGTH = 2'd1,
    REG_INIT_THR    = 2'd2
  } tcw_reg_e;

  // One entry of the per-byte store: sent flag and saturating ack count.
  typedef struct packed {
    logic       sent;
    logic [2:0] cnt;
  } tcw_entry_t;

  typedef struct packed {
    tcw_kind_e   kind;
    logic [15:0] seq;
    logic [5:0]  window;
    logic [7:0]  threshold;
    logic        last;
  } tcw_result_t;

endpackage

`default_nettype wire

FILE: rtl/core/tcw_if.sv
// Request and response channel interfaces of the congestion window controller.
// Depends on tcw_pkg for the action and kind codes.
`default_nettype none

interface tcw_req_if import tcw_pkg::*;;
  logic        valid;
  logic        ready;
  tcw_action_e action;
  logic [15:0] ack_number;

  modport source (output valid, output action, output ack_number, input ready);
  modport sink   (input valid, input action, input ack_number, output ready);
endinterface

interface tcw_rsp_if import tcw_pkg::*;;
  logic        valid;
  logic        ready;
  tcw_kind_e   kind;
  logic [15:0] seq_number;
  logic [5:0]  window;
  logic [7:0]  threshold;
  logic        last;

  modport source (output valid, output kind, output seq_number, output window,
                  output threshold, output last, input ready);
  modport sink   (input valid, input kind, input seq_number, input window,
                  input threshold, input last, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/tahoe_congestion_window_control.sv
// Sender-side congestion window controller; uses tcw_pkg, tcw_if and the assert macros.
// A duplicate ack goes through a store read, an ack that grows cwnd in congestion avoidance
// also runs the 9-step divider, and a round start walks the window one entry per cycle
// through the store's port, unless a send must wait for the output.
// After reset a clearing pass zeroes the store; ready stays low then.
// A new request is taken while the previous item's final result waits in the output register.
`default_nettype none
`include "tahoe_congestion_window_control_assert.svh"

module tahoe_congestion_window_control import tcw_pkg::*; #(
  parameter int unsigned MAX_BYTES = 2048
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  tcw_req_if.sink             req_i,
  tcw_rsp_if.source           rsp_o,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [CfgAddrW-1:0] paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  localparam int unsigned       AddrW     = $clog2(MAX_BYTES);
  localparam logic signed [17:0] MaxBytesS = 18'(MAX_BYTES);
  localparam logic [AddrW-1:0]  LastAddr  = AddrW'(MAX_BYTES - 1);

  // The sequencer. One state per step; the read port of the store is issued one
  // state ahead of the state that consumes the registered read data.
  typedef enum logic [8:0] {
    ST_CLEAR = 9'b000000001,
    ST_IDLE  = 9'b000000010,
    ST_DEC   = 9'b000000100,
    ST_WIN   = 9'b000001000,
    ST_ACK   = 9'b000010000,
    ST_TMO   = 9'b000100000,
    ST_DIV   = 9'b001000000,
    ST_GROW  = 9'b010000000,
    ST_FLUSH = 9'b100000000
  } tcw_state_e;

  // A byte position is stored only if it lies inside the data and inside the store.
  function automatic logic in_rng(input logic signed [17:0] p, input logic [11:0] len);
    return !p[17] && (p < $signed({6'b0, len})) && (p < MaxBytesS);
  endfunction

  // Configuration registers.
  logic [15:0] seq_off_q;
  logic [11:0] data_len_q;
  logic [7:0]  init_thr_q;
  logic        cfg_we;

  // Controller state.
  tcw_state_e  state_q, state_d;
  logic [15:0] cwnd_q, cwnd_d;
  logic [7:0]  thr_q, thr_d;
  logic [15:0] next_seq_q, next_seq_d;
  logic [16:0] pend_q, pend_d;
  logic        finished_q, finished_d;
  logic [AddrW-1:0] clr_q, clr_d;

  // Per-request working registers.
  tcw_action_e act_q, act_d;
  logic [15:0] ack_q, ack_d;
  logic [AddrW-1:0] addr_q, addr_d;
  logic signed [17:0] b_q, b_d;
  logic [5:0]  win_q, win_d;
  logic [5:0]  idx_q, idx_d;
  logic [8:0]  div_q, div_d;
  logic [7:0]  rem_q, rem_d;
  logic [3:0]  dcnt_q, dcnt_d;

  // Result staging: one held result plus the output register.
  tcw_result_t hold_q, hold_d;
  logic        hold_valid_q, hold_valid_d;
  tcw_result_t out_q, out_d;
  logic        out_valid_q, out_valid_d;
  tcw_result_t emit_r;
  logic        emit_v;
  logic        out_free;
  logic        stall;
  logic        req_ready;

  // Per-byte store of sent flags and ack counts.
  tcw_entry_t  ent_mem_q [MAX_BYTES];
  tcw_entry_t  ent_rd_q;
  logic        mem_we;
  logic        mem_re;
  logic [AddrW-1:0] mem_waddr;
  logic [AddrW-1:0] mem_raddr;
  tcw_entry_t  mem_wdata;

  // Datapath helpers.
  logic [7:0]  whole;
  logic [15:0] sel_seq;
  logic signed [17:0] pos;
  logic        pos_in;
  logic        done_hit;
  logic signed [17:0] remaining;
  logic [7:0]  win_m;
  logic [5:0]  swnd;
  logic signed [17:0] b_nx;
  logic        b_in;
  logic [2:0]  cnt_inc;
  logic [8:0]  rt;
  logic [8:0]  rt_sub;
  logic        ge;
  logic [16:0] grown;

  // ---------------------------------------------------------------------------
  // Configuration port. Writes complete in the access phase; pready is tied
  // high so there are no wait states. Writing seq_offset also rewinds next_seq,
  // and writing initial_threshold also reloads the live threshold (see below).
  // ---------------------------------------------------------------------------
  assign pready = 1'b1;
  assign cfg_we = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_off_q  <= SeqOffsetRst;
      data_len_q <= DataLenRst;
      init_thr_q <= InitThrRst;
    end else if (cfg_we) begin
      unique case (paddr[3:2])
        REG_SEQ_OFFSET:  seq_off_q  <= pwdata[15:0];
        REG_DATA_LENGTH: data_len_q <= pwdata[11:0];
        REG_INIT_THR:    init_thr_q <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_SEQ_OFFSET:  prdata = {16'b0, seq_off_q};
      REG_DATA_LENGTH: prdata = {20'b0, data_len_q};
      REG_INIT_THR:    prdata = {24'b0, init_thr_q};
      default:         prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Shared position arithmetic. Round start and timeout work from next_seq,
  // acks from the acknowledged number; both become a signed byte position.
  // ---------------------------------------------------------------------------
  assign whole    = cwnd_q[15:8];
  assign sel_seq  = (act_q == ACT_ROUND || act_q == ACT_TIMEOUT) ? next_seq_q : ack_q;
  assign pos      = $signed({2'b00, sel_seq}) - $signed({2'b00, seq_off_q});
  assign pos_in   = in_rng(pos, data_len_q);
  assign done_hit = pos >= ($signed({6'b0, data_len_q}) - 18'sd1);

  // The send window is the smaller of floor(cwnd) and the remaining data,
  // clamped to zero below and to the window cap above.
  always_comb begin
    remaining = $signed({6'b0, data_len_q}) - pos;
    if (remaining[17] || remaining == '0) begin
      win_m = '0;
    end else if (remaining < $signed({10'b0, whole})) begin
      win_m = remaining[7:0];
    end else begin
      win_m = whole;
    end
    swnd = (win_m > 8'(WinCap)) ? 6'(WinCap) : win_m[5:0];
  end

  // Window walk: packets sit two data bytes apart.
  assign b_nx = b_q + 18'sd2;
  assign b_in = in_rng(b_q, data_len_q);

  assign cnt_inc = (ent_rd_q.cnt == CntMax) ? CntMax : ent_rd_q.cnt + 3'd1;

  // Restoring divider for 256 / floor(cwnd): one quotient bit per cycle. The
  // quotient register starts out holding the dividend and shifts it out as the
  // quotient bits shift in. The same register then feeds the cwnd adder.
  assign rt     = {rem_q, div_q[8]};
  assign ge     = rt >= {1'b0, whole};
  assign rt_sub = rt - {1'b0, whole};
  assign grown  = {1'b0, cwnd_q} + {8'b0, div_q};

  // Output side: the output register is free when empty or being taken.
  // A result can be staged only if the held one can move on.
  assign out_free = !out_valid_q || rsp_o.ready;
  assign stall    = hold_valid_q && !out_free;

  // ---------------------------------------------------------------------------
  // Sequencer.
  // ---------------------------------------------------------------------------
  always_comb begin
    state_d      = state_q;
    cwnd_d       = cwnd_q;
    thr_d        = thr_q;
    next_seq_d   = next_seq_q;
    pend_d       = pend_q;
    finished_d   = finished_q;
    clr_d        = clr_q;
    act_d        = act_q;
    ack_d        = ack_q;
    addr_d       = addr_q;
    b_d          = b_q;
    win_d        = win_q;
    idx_d        = idx_q;
    div_d        = div_q;
    rem_d        = rem_q;
    dcnt_d       = dcnt_q;
    hold_d       = hold_q;
    hold_valid_d = hold_valid_q;
    out_d        = out_q;
    out_valid_d  = out_valid_q;

    mem_we    = 1'b0;
    mem_waddr = addr_q;
    mem_wdata = '0;
    mem_re    = 1'b0;
    mem_raddr = pos[AddrW-1:0];

    emit_v           = 1'b0;
    emit_r           = '0;
    emit_r.threshold = thr_q;
    req_ready        = 1'b0;

    unique case (state_q)
      // Zero the store one entry per cycle after reset.
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_q;
        clr_d     = clr_q + 1'b1;
        if (clr_q == LastAddr) begin
          state_d = ST_IDLE;
        end
      end

      ST_IDLE: begin
        req_ready = 1'b1;
        if (req_i.valid) begin
          act_d   = req_i.action;
          ack_d   = req_i.ack_number;
          state_d = ST_DEC;
        end
      end

      // Dispatch on the request. Every branch stages a result here, issues a store read
      // for the state that follows, or, for a round start with a nonempty window, both.
      ST_DEC: begin
        state_d = ST_FLUSH;
        emit_v  = 1'b1;
        if (finished_q) begin
          emit_r.kind = KIND_DONE;
        end else if (pend_q[16] && (act_q == ACT_ROUND || act_q == ACT_TIMEOUT)) begin
          // A retransmit is still outstanding: repeat it.
          emit_r.kind = KIND_RETRANSMIT;
          emit_r.seq  = pend_q[15:0];
        end else if (pend_q[16]) begin
          // Either ack code completes the retransmit once the ack moves past it.
          emit_r.kind = KIND_ACK;
          emit_r.seq  = ack_q;
          if (ack_q > pend_q[15:0]) begin
            pend_d     = '0;
            next_seq_d = ack_q;
            if (pos_in) begin
              mem_we    = 1'b1;
              mem_waddr = pos[AddrW-1:0];
            end
          end
        end else if (act_q == ACT_ROUND) begin
          emit_r.kind   = KIND_WINDOW;
          emit_r.seq    = next_seq_q;
          emit_r.window = swnd;
          win_d         = swnd;
          idx_d         = '0;
          b_d           = pos;
          if (swnd != '0) begin
            mem_re  = 1'b1;
            state_d = ST_WIN;
          end
        end else if (act_q == ACT_TIMEOUT) begin
          if (pos_in) begin
            // The retransmitted byte keeps its count, so read it first.
            emit_v  = 1'b0;
            mem_re  = 1'b1;
            addr_d  = pos[AddrW-1:0];
            state_d = ST_TMO;
          end else begin
            pend_d           = {1'b1, next_seq_q};
            thr_d            = {1'b0, cwnd_q[15:9]};
            cwnd_d           = CwndOne;
            emit_r.kind      = KIND_RETRANSMIT;
            emit_r.seq       = next_seq_q;
            emit_r.threshold = {1'b0, cwnd_q[15:9]};
          end
        end else begin
          // Ordinary ack: it always becomes next_seq.
          next_seq_d = ack_q;
          if (done_hit) begin
            finished_d  = 1'b1;
            emit_r.kind = KIND_DONE;
          end else if (!pos_in) begin
            emit_r.kind = KIND_ACK;
            emit_r.seq  = ack_q;
          end else begin
            emit_v  = 1'b0;
            mem_re  = 1'b1;
            addr_d  = pos[AddrW-1:0];
            state_d = ST_ACK;
          end
        end
      end

      // One window entry per cycle. The write of this entry and the read of
      // the next never collide since entries are two bytes apart. If a send
      // must wait for the output, the read data register simply holds.
      ST_WIN: begin
        if (b_in && !ent_rd_q.sent) begin
          emit_v      = 1'b1;
          emit_r.kind = KIND_SEND;
          emit_r.seq  = b_q[15:0] + seq_off_q;
        end
        if (!(emit_v && stall)) begin
          if (emit_v) begin
            mem_we         = 1'b1;
            mem_waddr      = b_q[AddrW-1:0];
            mem_wdata.sent = 1'b1;
            mem_wdata.cnt  = ent_rd_q.cnt;
          end
          if (idx_q + 6'd1 == win_q) begin
            state_d = ST_FLUSH;
          end else begin
            idx_d     = idx_q + 6'd1;
            b_d       = b_nx;
            mem_re    = 1'b1;
            mem_raddr = b_nx[AddrW-1:0];
          end
        end
      end

      // Count the ack. A fourth one starts a retransmit; the first one grows
      // cwnd, either by a whole packet or by 256/floor(cwnd) via the divider.
      ST_ACK: begin
        mem_we         = 1'b1;
        mem_wdata.sent = ent_rd_q.sent;
        mem_wdata.cnt  = cnt_inc;
        if (cnt_inc > DupLimit) begin
          mem_wdata.sent   = 1'b1;
          pend_d           = {1'b1, next_seq_q};
          thr_d            = {1'b0, cwnd_q[15:9]};
          cwnd_d           = CwndOne;
          emit_v           = 1'b1;
          emit_r.kind      = KIND_RETRANSMIT;
          emit_r.seq       = next_seq_q;
          emit_r.threshold = {1'b0, cwnd_q[15:9]};
          state_d          = ST_FLUSH;
        end else if (cnt_inc == 3'd1) begin
          div_d  = CwndStep;
          rem_d  = '0;
          dcnt_d = '0;
          if (cwnd_q < {thr_q, 8'b0} || whole == '0) begin
            state_d = ST_GROW;
          end else begin
            state_d = ST_DIV;
          end
        end else begin
          emit_v      = 1'b1;
          emit_r.kind = KIND_ACK;
          emit_r.seq  = ack_q;
          state_d     = ST_FLUSH;
        end
      end

      ST_TMO: begin
        mem_we           = 1'b1;
        mem_wdata.sent   = 1'b1;
        mem_wdata.cnt    = ent_rd_q.cnt;
        pend_d           = {1'b1, next_seq_q};
        thr_d            = {1'b0, cwnd_q[15:9]};
        cwnd_d           = CwndOne;
        emit_v           = 1'b1;
        emit_r.kind      = KIND_RETRANSMIT;
        emit_r.seq       = next_seq_q;
        emit_r.threshold = {1'b0, cwnd_q[15:9]};
        state_d          = ST_FLUSH;
      end

      ST_DIV: begin
        rem_d  = ge ? rt_sub[7:0] : rt[7:0];
        div_d  = {div_q[7:0], ge};
        dcnt_d = dcnt_q + 4'd1;
        if (dcnt_q == DivLastStep) begin
          state_d = ST_GROW;
        end
      end

      // cwnd saturates at the window cap.
      ST_GROW: begin
        cwnd_d      = (grown > CwndCap) ? CwndCap[15:0] : grown[15:0];
        emit_v      = 1'b1;
        emit_r.kind = KIND_ACK;
        emit_r.seq  = ack_q;
        state_d     = ST_FLUSH;
      end

      // Hand the held result to the output register as the last one.
      ST_FLUSH: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase

    // The user must issue configuration writes only while idle; the block itself does not enforce it.
    if (cfg_we) begin
      unique case (paddr[3:2])
        REG_SEQ_OFFSET: next_seq_d = pwdata[15:0];
        REG_INIT_THR:   thr_d      = pwdata[7:0];
        default: ;
      endcase
    end

    // Result staging. Each new result pushes the held one out with last low;
    // the flush pushes the final one out with last high.
    if (out_valid_q && rsp_o.ready) begin
      out_valid_d = 1'b0;
    end
    if (emit_v && !stall) begin
      if (hold_valid_q) begin
        out_d       = hold_q;
        out_valid_d = 1'b1;
      end
      hold_d       = emit_r;
      hold_valid_d = 1'b1;
    end
    if (state_q == ST_FLUSH && out_free) begin
      out_d        = hold_q;
      out_d.last   = 1'b1;
      out_valid_d  = 1'b1;
      hold_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_CLEAR;
      cwnd_q       <= CwndOne;
      thr_q        <= InitThrRst;
      next_seq_q   <= SeqOffsetRst;
      pend_q       <= '0;
      finished_q   <= 1'b0;
      clr_q        <= '0;
      win_q        <= '0;
      idx_q        <= '0;
      dcnt_q       <= '0;
      hold_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      cwnd_q       <= cwnd_d;
      thr_q        <= thr_d;
      next_seq_q   <= next_seq_d;
      pend_q       <= pend_d;
      finished_q   <= finished_d;
      clr_q        <= clr_d;
      win_q        <= win_d;
      idx_q        <= idx_d;
      dcnt_q       <= dcnt_d;
      hold_valid_q <= hold_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    act_q  <= act_d;
    ack_q  <= ack_d;
    addr_q <= addr_d;
    b_q    <= b_d;
    div_q  <= div_d;
    rem_q  <= rem_d;
    hold_q <= hold_d;
    out_q  <= out_d;
  end

  // Store: one write and one registered read per cycle.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      ent_mem_q[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      ent_rd_q <= ent_mem_q[mem_raddr];
    end
  end

  // Channel wiring.
  assign req_i.ready      = req_ready;
  assign rsp_o.valid      = out_valid_q;
  assign rsp_o.kind       = out_q.kind;
  assign rsp_o.seq_number = out_q.seq;
  assign rsp_o.window     = out_q.window;
  assign rsp_o.threshold  = out_q.threshold;
  assign rsp_o.last       = out_q.last;

  // ---------------------------------------------------------------------------
  // Assertions.
  // ---------------------------------------------------------------------------
  `TCW_ASSERT_IMPL(a_ready_hold_empty, clk_i, rst_ni, req_ready, !hold_valid_q,
                   "request taken while a result is still staged")
  `TCW_ASSERT_IMPL(a_cwnd_range, clk_i, rst_ni, 1'b1,
                   (cwnd_q >= CwndOne) && ({1'b0, cwnd_q} <= CwndCap),
                   "cwnd left its legal range")
  `TCW_ASSERT_IMPL(a_window_cap, clk_i, rst_ni,
                   out_valid_q && (out_q.kind == KIND_WINDOW), out_q.window <= 6'(WinCap),
                   "window report above the cap")
  `TCW_ASSERT_IMPL(a_div_nonzero, clk_i, rst_ni, state_q == ST_DIV, whole != '0,
                   "divider running with a zero divisor")
  `TCW_ASSERT_NEXT(a_flush_last, clk_i, rst_ni, (state_q == ST_FLUSH) && out_free,
                   out_valid_q && out_q.last && !hold_valid_q,
                   "flush did not deliver a final result")

endmodule

`default_nettype wire
